// File: src/lcdns_pkg.sv
// ---------------------------------------------------------------------------
// lcdns_pkg
// Types, constants and the control store of the character LCD nibble
// sequencer.
// ---------------------------------------------------------------------------
package lcdns_pkg;

    localparam int NUM_ROWS         = 2;
    localparam int NIBBLE_SETTLE_US = 100;

    localparam int HOLD_W    = 16;
    localparam int PROG_LEN  = 15;
    localparam int STEP_W    = $clog2(PROG_LEN);
    localparam int PHASE_W   = 2;
    localparam int ROW_W     = 2;
    localparam int COL_W     = 7;

    localparam logic [HOLD_W-1:0] POWER_WAIT_US = HOLD_W'(50000);
    localparam logic [HOLD_W-1:0] EDGE_US       = HOLD_W'(1);
    localparam logic [HOLD_W-1:0] SETTLE_US     = HOLD_W'(NIBBLE_SETTLE_US);

    localparam logic [1:0] KIND_POWER_UP = 2'd0;
    localparam logic [1:0] KIND_COMMAND  = 2'd1;
    localparam logic [1:0] KIND_DATA     = 2'd2;
    localparam logic [1:0] KIND_CURSOR   = 2'd3;

    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_HOME_ALT  = 8'h03;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

    localparam logic [STEP_W-1:0] ENTRY_POWER_UP = STEP_W'(0);
    localparam logic [STEP_W-1:0] ENTRY_REQUEST  = STEP_W'(13);

    localparam logic [PHASE_W-1:0] PHASE_SETUP  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_STROBE = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_SETTLE = 2'd2;

    typedef enum logic [1:0] {
        OP_IDLE = 2'd0,
        OP_HI   = 2'd1,
        OP_LO   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        EXTRA_NONE = 3'd0,
        EXTRA_5000 = 3'd1,
        EXTRA_150  = 3'd2,
        EXTRA_2000 = 3'd3,
        EXTRA_CMD  = 3'd4
    } extra_t;

    typedef struct packed {
        op_t        op;
        logic       use_req;
        logic [7:0] value;
        extra_t     extra;
        logic       stop;
    } ctrl_word_t;

    function automatic ctrl_word_t prog_word(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w = '{op: OP_IDLE, use_req: 1'b0, value: 8'h00, extra: EXTRA_NONE, stop: 1'b1};
        case (step)
            STEP_W'(0):  w = '{OP_IDLE, 1'b0, 8'h00, EXTRA_NONE, 1'b0};
            STEP_W'(1):  w = '{OP_LO,   1'b0, 8'h03, EXTRA_5000, 1'b0};
            STEP_W'(2):  w = '{OP_LO,   1'b0, 8'h03, EXTRA_5000, 1'b0};
            STEP_W'(3):  w = '{OP_LO,   1'b0, 8'h03, EXTRA_150,  1'b0};
            STEP_W'(4):  w = '{OP_LO,   1'b0, 8'h02, EXTRA_NONE, 1'b0};
            STEP_W'(5):  w = '{OP_HI,   1'b0, 8'h28, EXTRA_NONE, 1'b0};
            STEP_W'(6):  w = '{OP_LO,   1'b0, 8'h28, EXTRA_NONE, 1'b0};
            STEP_W'(7):  w = '{OP_HI,   1'b0, 8'h0C, EXTRA_NONE, 1'b0};
            STEP_W'(8):  w = '{OP_LO,   1'b0, 8'h0C, EXTRA_NONE, 1'b0};
            STEP_W'(9):  w = '{OP_HI,   1'b0, 8'h01, EXTRA_NONE, 1'b0};
            STEP_W'(10): w = '{OP_LO,   1'b0, 8'h01, EXTRA_2000, 1'b0};
            STEP_W'(11): w = '{OP_HI,   1'b0, 8'h06, EXTRA_NONE, 1'b0};
            STEP_W'(12): w = '{OP_LO,   1'b0, 8'h06, EXTRA_NONE, 1'b1};
            STEP_W'(13): w = '{OP_HI,   1'b1, 8'h00, EXTRA_NONE, 1'b0};
            STEP_W'(14): w = '{OP_LO,   1'b1, 8'h00, EXTRA_CMD,  1'b1};
            default:     w = '{OP_IDLE, 1'b0, 8'h00, EXTRA_NONE, 1'b1};
        endcase
        return w;
    endfunction

    function automatic logic [COL_W-1:0] row_base(input logic [ROW_W-1:0] row);
        logic [COL_W-1:0] b;
        case (row)
            2'd0:    b = 7'h00;
            2'd1:    b = 7'h40;
            2'd2:    b = 7'h10;
            2'd3:    b = 7'h50;
            default: b = 7'h00;
        endcase
        return b;
    endfunction

endpackage

// File: src/char_lcd_nibble_sequencer.sv
// ---------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Expands LCD requests into timed phases of a 4-bit character LCD bus.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one request: kind selects
//   power-up, command byte, data byte or set cursor; byte_value, column and
//   line are used by the kinds that need them.
//   Output channel (out_valid/out_ready) gives one bus phase per transfer:
//   reg_select, nibble, enable, hold_us, with last set on the final phase.
//   A small control store runs the request, one control word per nibble
//   (power-up adds a wait word); a phase counter walks each nibble through setup, strobe and settle.
//   The first phase is shown once the accepted request has set the sequencer
//   state and the output register has loaded it, then one phase per cycle while
//   out_ready stays high: 6 phases for a byte request, 37 for power-up.
//   in_ready rises together with the final phase on the output, so the next
//   request can be taken while that phase is shown.
//   A stalled receiver holds the output register and freezes the sequencer.
//   Reset empties the output register and leaves the block ready.
// ---------------------------------------------------------------------------
module char_lcd_nibble_sequencer
    import lcdns_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           kind,
    input  logic [7:0]           byte_value,
    input  logic [COL_W-1:0]     column,
    input  logic [ROW_W-1:0]     line,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 reg_select,
    output logic [3:0]           nibble,
    output logic                 enable,
    output logic [HOLD_W-1:0]    hold_us,
    output logic                 last
);

    logic                busy_reg,   busy_next;
    logic [STEP_W-1:0]   step_reg,   step_next;
    logic [PHASE_W-1:0]  phase_reg,  phase_next;
    logic                ovalid_reg, ovalid_next;

    logic [7:0]          req_byte_reg;
    logic                req_rs_reg;
    logic                req_wait_reg;

    logic                rs_reg;
    logic [3:0]          nib_reg;
    logic                en_reg;
    logic [HOLD_W-1:0]   hold_reg;
    logic                last_reg;

    logic                accept;
    logic                load;
    logic                final_phase;
    ctrl_word_t          cw;
    logic [7:0]          src_byte;
    logic [3:0]          cur_nib;
    logic                cur_en;
    logic [HOLD_W-1:0]   extra_us;
    logic [HOLD_W-1:0]   cur_hold;
    logic [ROW_W-1:0]    row_clamped;
    logic [COL_W-1:0]    cursor_addr;
    logic [7:0]          req_byte;
    logic                req_wait;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && !busy_reg;
    assign load     = busy_reg && (!ovalid_reg || out_ready);

    // request byte is settled at the transfer, so the datapath only needs
    // the latched copy
    always_comb
    begin
        row_clamped = (32'(line) >= NUM_ROWS) ? ROW_W'(NUM_ROWS - 1) : line;
        cursor_addr = column + row_base(row_clamped);
        case (kind)
            KIND_CURSOR: req_byte = CMD_SET_DDRAM | {1'b0, cursor_addr};
            default:     req_byte = byte_value;
        endcase
        req_wait = (kind == KIND_COMMAND) &&
                   (byte_value == CMD_CLEAR || byte_value == CMD_HOME ||
                    byte_value == CMD_HOME_ALT);
    end

    always_comb
    begin
        cw       = prog_word(step_reg);
        src_byte = cw.use_req ? req_byte_reg : cw.value;
        case (cw.op)
            OP_HI:   cur_nib = src_byte[7:4];
            OP_LO:   cur_nib = src_byte[3:0];
            default: cur_nib = 4'h0;
        endcase
        case (cw.extra)
            EXTRA_5000: extra_us = HOLD_W'(5000);
            EXTRA_150:  extra_us = HOLD_W'(150);
            EXTRA_2000: extra_us = HOLD_W'(2000);
            EXTRA_CMD:  extra_us = req_wait_reg ? HOLD_W'(2000) : '0;
            default:    extra_us = '0;
        endcase
        final_phase = (cw.op == OP_IDLE) || (phase_reg == PHASE_SETTLE);
        cur_en      = (cw.op != OP_IDLE) && (phase_reg == PHASE_STROBE);
        if (cw.op == OP_IDLE)
            cur_hold = POWER_WAIT_US;
        else if (phase_reg == PHASE_SETTLE)
            cur_hold = SETTLE_US + extra_us;
        else
            cur_hold = EDGE_US;
    end

    always_comb
    begin
        busy_next   = busy_reg;
        step_next   = step_reg;
        phase_next  = phase_reg;
        ovalid_next = ovalid_reg;
        if (out_ready)
            ovalid_next = 1'b0;
        if (load)
        begin
            ovalid_next = 1'b1;
            if (final_phase)
            begin
                phase_next = PHASE_SETUP;
                if (cw.stop)
                    busy_next = 1'b0;
                else
                    step_next = step_reg + STEP_W'(1);
            end
            else
            begin
                phase_next = phase_reg + PHASE_W'(1);
            end
        end
        if (accept)
        begin
            busy_next  = 1'b1;
            phase_next = PHASE_SETUP;
            step_next  = (kind == KIND_POWER_UP) ? ENTRY_POWER_UP : ENTRY_REQUEST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= '0;
            phase_reg  <= PHASE_SETUP;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            phase_reg  <= phase_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_byte_reg <= req_byte;
            req_rs_reg   <= (kind == KIND_DATA);
            req_wait_reg <= req_wait;
        end
        if (load)
        begin
            rs_reg   <= cw.use_req ? req_rs_reg : 1'b0;
            nib_reg  <= cur_nib;
            en_reg   <= cur_en;
            hold_reg <= cur_hold;
            last_reg <= final_phase && cw.stop;
        end
    end

    assign out_valid  = ovalid_reg;
    assign reg_select = rs_reg;
    assign nibble     = nib_reg;
    assign enable     = en_reg;
    assign hold_us    = hold_reg;
    assign last       = last_reg;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && phase_reg == PHASE_SETUP)
        else $error("transfer taken but sequencer did not start");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        load && final_phase && cw.stop |=> out_valid && last && !busy_reg)
        else $error("final phase loaded but sequencer still busy");

    a_strobe_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && enable |-> hold_us == EDGE_US && !last)
        else $error("enable high phase with wrong hold or last flag");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> phase_reg != 2'd3 && 32'(step_reg) < PROG_LEN)
        else $error("sequencer counters out of range");
`endif

endmodule

// File: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the character LCD nibble sequencer. Requests go in
// through a queue-fed driver. Every bus phase that comes out is compared,
// field by field, with the phases that a local expansion of each accepted
// request predicts. Both sides of the handshake idle at random. The receiver
// also holds off once for a long stretch so that the block stalls its input.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdns_pkg::*;

    localparam int unsigned WAKE_WAIT_US  = 5000;
    localparam int unsigned WAKE_LAST_US  = 150;
    localparam int unsigned CLEAR_WAIT_US = 2000;
    localparam int unsigned SETTLE        = NIBBLE_SETTLE_US;
    localparam int          NUM_CHUNKS    = 5;
    localparam int          CHUNK_ITEMS   = 40;
    localparam int          LONG_HOLD_OFF = 300;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES  = 20;

    localparam logic [COL_W-1:0] ROW_START [4] = '{7'h00, 7'h40, 7'h10, 7'h50};

    typedef struct {
        logic [1:0]       kind;
        logic [7:0]       byte_value;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] line;
    } lcd_request_t;

    typedef struct {
        logic              reg_select;
        logic [3:0]        nibble;
        logic              enable;
        logic [HOLD_W-1:0] hold_us;
        logic              last;
    } bus_phase_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    logic [1:0]           kind       = KIND_POWER_UP;
    logic [7:0]           byte_value = 8'h00;
    logic [COL_W-1:0]     column     = '0;
    logic [ROW_W-1:0]     line       = '0;
    logic                 out_valid;
    logic                 out_ready  = 1'b0;
    logic                 reg_select;
    logic [3:0]           nibble;
    logic                 enable;
    logic [HOLD_W-1:0]    hold_us;
    logic                 last;

    lcd_request_t request_backlog[$];
    bus_phase_t   phase_expect[$];

    // local copy of the sequencer state
    logic [5:0]   phases_in_request = '0;
    logic [7:0]   bus_byte          = '0;
    logic         bus_select        = 1'b0;

    int           mismatches    = 0;
    int           tx_idle_pct   = 0;
    int           rx_idle_pct   = 0;
    logic         calm          = 1'b0;
    logic         long_hold_go  = 1'b0;
    logic         long_hold_done = 1'b0;
    int           long_hold_left = 0;
    int           tx_gap        = 0;
    int           rx_gap        = 0;
    int           quiet_cycles  = 0;

    char_lcd_nibble_sequencer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .byte_value (byte_value),
        .column     (column),
        .line       (line),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .reg_select (reg_select),
        .nibble     (nibble),
        .enable     (enable),
        .hold_us    (hold_us),
        .last       (last)
    );

    always #1 clk = ~clk;

    // -----------------------------------------------------------------------
    // Phase prediction
    // -----------------------------------------------------------------------
    function automatic void add_phase(logic rs, logic [3:0] nib, logic en,
                                      int unsigned hold);
        bus_phase_t p;
        p.reg_select = rs;
        p.nibble     = nib;
        p.enable     = en;
        p.hold_us    = hold[HOLD_W-1:0];
        p.last       = 1'b0;
        phase_expect.push_back(p);
        phases_in_request = phases_in_request + 6'd1;
    endfunction

    function automatic void add_nibble(logic rs, logic [3:0] nib, int unsigned extra);
        add_phase(rs, nib, 1'b0, 1);
        add_phase(rs, nib, 1'b1, 1);
        add_phase(rs, nib, 1'b0, SETTLE + extra);
        bus_select = rs;
    endfunction

    function automatic void add_byte(logic rs, logic [7:0] b, int unsigned extra);
        add_nibble(rs, b[7:4], 0);
        add_nibble(rs, b[3:0], extra);
        bus_byte = b;
    endfunction

    function automatic void expand_request(lcd_request_t r);
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] addr;
        phases_in_request = '0;
        case (r.kind)
            KIND_POWER_UP: begin
                add_phase(1'b0, 4'h0, 1'b0, POWER_WAIT_US);
                bus_select = 1'b0;
                add_nibble(1'b0, 4'h3, WAKE_WAIT_US);
                add_nibble(1'b0, 4'h3, WAKE_WAIT_US);
                add_nibble(1'b0, 4'h3, WAKE_LAST_US);
                add_nibble(1'b0, 4'h2, 0);
                add_byte(1'b0, 8'h28, 0);
                add_byte(1'b0, 8'h0C, 0);
                add_byte(1'b0, CMD_CLEAR, CLEAR_WAIT_US);
                add_byte(1'b0, 8'h06, 0);
            end
            KIND_COMMAND: begin
                // clear and both home codes need the long wait
                if (r.byte_value == CMD_CLEAR || r.byte_value == CMD_HOME ||
                    r.byte_value == CMD_HOME_ALT)
                    add_byte(1'b0, r.byte_value, CLEAR_WAIT_US);
                else
                    add_byte(1'b0, r.byte_value, 0);
            end
            KIND_DATA: add_byte(1'b1, r.byte_value, 0);
            default: begin
                row = r.line;
                if (row >= NUM_ROWS)
                    row = ROW_W'(NUM_ROWS - 1);
                addr = r.column + ROW_START[row];
                add_byte(1'b0, CMD_SET_DDRAM | {1'b0, addr}, 0);
            end
        endcase
        phase_expect[phase_expect.size() - 1].last = 1'b1;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    function automatic lcd_request_t make_request(logic [1:0] k, logic [7:0] b,
                                                  logic [COL_W-1:0] c,
                                                  logic [ROW_W-1:0] r);
        lcd_request_t q;
        q.kind       = k;
        q.byte_value = b;
        q.column     = c;
        q.line       = r;
        return q;
    endfunction

    function automatic lcd_request_t random_request();
        lcd_request_t q;
        int unsigned  pick;
        q = make_request(2'($urandom), 8'($urandom), COL_W'($urandom), ROW_W'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 4)
            q.kind = KIND_POWER_UP;
        else if (pick < 34) begin
            q.kind = KIND_COMMAND;
            // favour the codes that carry the long wait
            case ($urandom_range(0, 9))
                0: q.byte_value = CMD_CLEAR;
                1: q.byte_value = CMD_HOME;
                2: q.byte_value = CMD_HOME_ALT;
                default: ;
            endcase
        end
        else if (pick < 67)
            q.kind = KIND_DATA;
        else
            q.kind = KIND_CURSOR;
        return q;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // -----------------------------------------------------------------------
    // Request driver
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        lcd_request_t r;
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap   = 0;
        end
        else if (!in_valid || in_ready) begin
            if (in_valid)
                expand_request(make_request(kind, byte_value, column, line));
            if (tx_gap > 0) begin
                tx_gap = tx_gap - 1;
                in_valid <= 1'b0;
            end
            else if (request_backlog.size() > 0) begin
                if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
                    tx_gap = $urandom_range(0, 4);
                    in_valid <= 1'b0;
                end
                else begin
                    r = request_backlog.pop_front();
                    kind       <= r.kind;
                    byte_value <= r.byte_value;
                    column     <= r.column;
                    line       <= r.line;
                    in_valid   <= 1'b1;
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: random bursts of back-pressure plus one long hold-off
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_gap    = 0;
        end
        else if (long_hold_left > 0) begin
            long_hold_left = long_hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (long_hold_go && !long_hold_done) begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD_OFF;
            out_ready <= 1'b0;
        end
        else if (rx_gap > 0) begin
            rx_gap = rx_gap - 1;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
            rx_gap = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // -----------------------------------------------------------------------
    // Monitor
    // -----------------------------------------------------------------------
    always @(posedge clk) begin
        bus_phase_t want;
        if (rst_n && out_valid && out_ready) begin
            if (phase_expect.size() == 0) begin
                $display("%0t: unexpected phase, expected none actual rs=%0d nib=%0h en=%0d hold=%0d last=%0d",
                         $time, reg_select, nibble, enable, hold_us, last);
                mismatches++;
            end
            else begin
                want = phase_expect.pop_front();
                check_field("reg_select", want.reg_select, reg_select);
                check_field("nibble",     want.nibble,     nibble);
                check_field("enable",     want.enable,     enable);
                check_field("hold_us",    want.hold_us,    hold_us);
                check_field("last",       want.last,       last);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: end the run if no transfer happens for too long
    // -----------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sequence of the run
    // -----------------------------------------------------------------------
    initial begin
        int pct_choice [3];
        pct_choice = '{0, 15, 40};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct <= 20;
        rx_idle_pct <= 20;

        // directed: field extremes, every kind, long-wait codes, row clamp and wrap
        request_backlog.push_back(make_request(KIND_POWER_UP, 8'h00, 7'h00, 2'd0));
        request_backlog.push_back(make_request(KIND_COMMAND,  8'h00, 7'h7F, 2'd3));
        request_backlog.push_back(make_request(KIND_COMMAND,  8'hFF, 7'h00, 2'd0));
        request_backlog.push_back(make_request(KIND_COMMAND,  CMD_CLEAR, 7'h00, 2'd0));
        request_backlog.push_back(make_request(KIND_COMMAND,  CMD_HOME, 7'h00, 2'd0));
        request_backlog.push_back(make_request(KIND_COMMAND,  CMD_HOME_ALT, 7'h00, 2'd0));
        request_backlog.push_back(make_request(KIND_COMMAND,  8'h04, 7'h00, 2'd0));
        request_backlog.push_back(make_request(KIND_COMMAND,  8'h28, 7'h00, 2'd0));
        request_backlog.push_back(make_request(KIND_DATA,     8'h00, 7'h7F, 2'd3));
        request_backlog.push_back(make_request(KIND_DATA,     8'hFF, 7'h00, 2'd0));
        request_backlog.push_back(make_request(KIND_DATA,     8'hA5, 7'h00, 2'd0));
        request_backlog.push_back(make_request(KIND_DATA,     8'h5A, 7'h00, 2'd0));
        request_backlog.push_back(make_request(KIND_CURSOR,   8'hFF, 7'h00, 2'd0));
        request_backlog.push_back(make_request(KIND_CURSOR,   8'h00, 7'h7F, 2'd1));
        request_backlog.push_back(make_request(KIND_CURSOR,   8'h00, 7'h7F, 2'd3));
        request_backlog.push_back(make_request(KIND_CURSOR,   8'h00, 7'h3F, 2'd2));
        request_backlog.push_back(make_request(KIND_CURSOR,   8'h00, 7'h40, 2'd1));
        request_backlog.push_back(make_request(KIND_CURSOR,   8'h00, 7'h55, 2'd0));
        request_backlog.push_back(make_request(KIND_POWER_UP, 8'hFF, 7'h7F, 2'd3));
        request_backlog.push_back(make_request(KIND_COMMAND,  8'h80, 7'h2A, 2'd2));

        // hold the sender until every phase of the directed part is back
        while (request_backlog.size() > 0 || in_valid || phase_expect.size() > 0)
            @(posedge clk);

        long_hold_go <= 1'b1;
        for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
            while (request_backlog.size() > 0)
                @(posedge clk);
            if (chunk == NUM_CHUNKS - 1)
                calm <= 1'b1;
            else begin
                tx_idle_pct <= pct_choice[$urandom_range(0, 2)];
                rx_idle_pct <= pct_choice[$urandom_range(0, 2)];
            end
            for (int i = 0; i < CHUNK_ITEMS; i++)
                request_backlog.push_back(random_request());
        end

        while (request_backlog.size() > 0 || in_valid || phase_expect.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && phase_expect.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
